/* rtl/scc_pkg.sv */
// Shared types and constants of the sliding cross-correlation block.
`default_nettype none

package scc_pkg;

   // Field widths
   localparam int INDEX_W  = 6;
   localparam int SAMPLE_W = 16;
   localparam int PROD_W   = 32;
   localparam int CORR_W   = 38;

   // Operation codes of an input transfer
   localparam logic OP_TEMPLATE = 1'b0;
   localparam logic OP_SAMPLE   = 1'b1;

   // Controller states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_WAIT
   } ctrl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic clear;       // zero one entry of both memories
      logic tmpl_write;  // write one template entry
      logic push;        // store a sample and start a new sum
      logic issue;       // read one tap pair into the MAC pipe
      logic publish;     // move the finished sum to the output register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic clear_last;  // clearing pass is at its last entry
      logic issue_last;  // last tap pair is being read
      logic mac_done;    // accumulator holds the finished sum
      logic out_free;    // output register can take a new result
   } status_type;

endpackage

`default_nettype wire

/* rtl/scc_req_if.sv */
// Input channel: template writes and stream samples.
`default_nettype none

interface scc_req_if;
   import scc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [INDEX_W-1:0]         tap_index;
   logic signed [SAMPLE_W-1:0] template_value;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output op, output tap_index,
                   output template_value, output sample, input ready);
   modport sink   (input valid, input op, input tap_index,
                   input template_value, input sample, output ready);
endinterface

`default_nettype wire

/* rtl/scc_rsp_if.sv */
// Result channel: one correlation sum per sample.
`default_nettype none

interface scc_rsp_if;
   import scc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [CORR_W-1:0] correlation;

   modport source (output valid, output correlation, input ready);
   modport sink   (input valid, input correlation, output ready);
endinterface

`default_nettype wire

/* rtl/scc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module scc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/scc_datapath.sv */
// Datapath: sample ring, template store, shared multiply-accumulate, result register.
`default_nettype none

module scc_datapath #(
   parameter int TAPS = 64,
   parameter int AW   = (TAPS > 1) ? $clog2(TAPS) : 1
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire scc_pkg::cmd_type                            cmd,
   output scc_pkg::status_type                              status,
   input  wire logic [scc_pkg::INDEX_W-1:0]                 tap_index,
   input  wire logic signed [scc_pkg::SAMPLE_W-1:0]         template_value,
   input  wire logic signed [scc_pkg::SAMPLE_W-1:0]         sample,
   input  wire logic                                        rsp_ready,
   output logic                                             rsp_valid,
   output logic signed [scc_pkg::CORR_W-1:0]                rsp_correlation
);
   import scc_pkg::*;

   localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

   // Control registers
   logic [AW-1:0] count_ff, count_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] ring_rd_ff, ring_rd_in;
   logic          vld1_ff, last1_ff, vld2_ff, last2_ff, done_ff, rsp_valid_ff;

   // Payload registers
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [CORR_W-1:0] acc_ff, acc_in;
   logic signed [CORR_W-1:0] result_ff;

   // Memory ports
   logic                 tmpl_we, ring_we;
   logic [AW-1:0]        tmpl_waddr, ring_waddr;
   logic [SAMPLE_W-1:0]  tmpl_wdata, ring_wdata, tmpl_rdata, ring_rdata;
   logic [31:0]          tap_wide;
   logic                 tap_in_range;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
      return (x == LAST) ? '0 : x + AW'(1);
   endfunction

   // Decode the template address; entries past the window are dropped
   assign tap_wide     = 32'(tap_index);
   assign tap_in_range = tap_wide < 32'(TAPS);

   // Select write ports: clearing pass or normal traffic
   assign tmpl_we    = cmd.clear | (cmd.tmpl_write & tap_in_range);
   assign tmpl_waddr = cmd.clear ? count_ff : tap_wide[AW-1:0];
   assign tmpl_wdata = cmd.clear ? '0 : template_value;
   assign ring_we    = cmd.clear | cmd.push;
   assign ring_waddr = cmd.clear ? count_ff : wp_ff;
   assign ring_wdata = cmd.clear ? '0 : sample;

   scc_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS), .AW(AW)) u_tmpl_ram (
      .clock   (clock),
      .wr_en   (tmpl_we),
      .wr_addr (tmpl_waddr),
      .wr_data (tmpl_wdata),
      .rd_addr (count_ff),
      .rd_data (tmpl_rdata)
   );

   scc_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS), .AW(AW)) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_addr (ring_rd_ff),
      .rd_data (ring_rdata)
   );

   // Advance counters: template index j pairs with ring slot wp+1+j
   always_comb begin
      count_in   = count_ff;
      wp_in      = wp_ff;
      ring_rd_in = ring_rd_ff;
      if (cmd.clear || cmd.issue) begin
         count_in   = wrap_inc(count_ff);
         ring_rd_in = wrap_inc(ring_rd_ff);
      end
      if (cmd.push) begin
         count_in   = '0;
         ring_rd_in = wrap_inc(wp_ff);
         wp_in      = wrap_inc(wp_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         wp_ff      <= '0;
         ring_rd_ff <= '0;
      end else begin
         count_ff   <= count_in;
         wp_ff      <= wp_in;
         ring_rd_ff <= ring_rd_in;
      end
   end

   // Track tap pairs through read and multiply stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff  <= 1'b0;
         last1_ff <= 1'b0;
         vld2_ff  <= 1'b0;
         last2_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         vld1_ff  <= cmd.issue;
         last1_ff <= cmd.issue & (count_ff == LAST);
         vld2_ff  <= vld1_ff;
         last2_ff <= last1_ff;
         if (cmd.push) begin
            done_ff <= 1'b0;
         end else if (last2_ff) begin
            done_ff <= 1'b1;
         end
      end
   end

   // Multiply one tap pair
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'($signed(tmpl_rdata)) * PROD_W'($signed(ring_rdata));
   end

   // Accumulate at full precision
   always_comb begin
      acc_in = acc_ff;
      if (cmd.push) begin
         acc_in = '0;
      end else if (vld2_ff) begin
         acc_in = acc_ff + CORR_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Hold the result until its transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         result_ff <= acc_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_correlation = result_ff;

   assign status.clear_last = count_ff == LAST;
   assign status.issue_last = count_ff == LAST;
   assign status.mac_done   = done_ff;
   assign status.out_free   = ~rsp_valid_ff | rsp_ready;

`ifndef SYNTHESIS
   a_publish_done: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> done_ff && !vld1_ff && !vld2_ff)
      else $error("result published before the sum finished");
   a_push_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !vld1_ff && !vld2_ff && !cmd.issue)
      else $error("new sample pushed while the MAC pipe is busy");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.publish))
      else $error("result valid without a publish");
`endif

endmodule

`default_nettype wire

/* rtl/scc_ctrl.sv */
// Controller: clearing pass, transfer acceptance and tap sequencing.
`default_nettype none

module scc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_op,
   output logic                     req_ready,
   input  wire scc_pkg::status_type status,
   output scc_pkg::cmd_type         cmd
);
   import scc_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid & req_ready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req_op == OP_SAMPLE) begin
               cmd.push = 1'b1;
               state_in = ST_RUN;
            end else if (accept && req_op == OP_TEMPLATE) begin
               cmd.tmpl_write = 1'b1;
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (status.issue_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (status.mac_done && status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_run_to_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && status.issue_last) |=> state_ff == ST_WAIT)
      else $error("tap sequence did not end after the last pair");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

/* rtl/sliding_cross_correlation_top.sv */
// Top level of the sliding cross-correlation block.
//
//   channel  | dir | payload                               | handshake
//   ---------+-----+---------------------------------------+-----------
//   req_if   | in  | op, tap_index, template_value, sample | valid/ready
//   rsp_if   | out | correlation (Q8.30, 38 bits signed)   | valid/ready
//
// A template transfer writes one entry and leaves req_if ready. For a sample,
// one shared multiply-accumulate walks the ring and template memories one tap
// pair a cycle through a three-stage read/multiply/accumulate pipe.
// After reset a clearing pass zeros both memories; req_if.ready stays low during
// it and while a sum is built. A result waits in its output register; a stalled
// rsp_if holds the next sum in the accumulator until the register is free.
`default_nettype none

module sliding_cross_correlation_top #(
   parameter int TAPS = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   scc_req_if.sink   req_if,
   scc_rsp_if.source rsp_if
);
   import scc_pkg::*;

   localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;

   cmd_type    cmd;
   status_type status;

   scc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_op    (req_if.op),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   scc_datapath #(.TAPS(TAPS), .AW(AW)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .tap_index       (req_if.tap_index),
      .template_value  (req_if.template_value),
      .sample          (req_if.sample),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_correlation (rsp_if.correlation)
   );

endmodule

`default_nettype wire
